// ===== design/swsed_pkg.sv =====
// Shared types and constants for the single-wire sensor edge decoder.
package swsed_pkg;

  typedef enum logic [1:0] {
    PH_INVALID = 2'd0,
    PH_WAKING  = 2'd1,
    PH_READING = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    OC_NONE     = 3'd0,
    OC_OK       = 3'd1,
    OC_WAKE_ERR = 3'd2,
    OC_DATA_ERR = 3'd3,
    OC_SUM_ERR  = 3'd4
  } outcome_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_EDGE  = 1'b1
  } op_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_ONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MAX  = 3'd4;

  localparam logic [15:0] WAKE_MIN_RST = 16'd115;
  localparam logic [15:0] WAKE_MAX_RST = 16'd190;
  localparam logic [15:0] BIT_MIN_RST  = 16'd60;
  localparam logic [15:0] BIT_ONE_RST  = 16'd100;
  localparam logic [15:0] BIT_MAX_RST  = 16'd145;

  localparam int unsigned FRAME_LEN = 5;
  localparam logic [7:0]  MAG_MASK  = 8'h7F;
  localparam logic [7:0]  SIGN_MASK = 8'h80;

  typedef struct packed {
    logic [15:0] wake_min_us;
    logic [15:0] wake_max_us;
    logic [15:0] bit_min_us;
    logic [15:0] bit_one_threshold_us;
    logic [15:0] bit_max_us;
  } cfg_t;

endpackage

// ===== design/swsed_in_if.sv =====
// Input channel: start requests and falling-edge timestamps.
interface swsed_in_if;
  logic              valid;
  logic              ready;
  swsed_pkg::op_t    operation;
  logic [31:0]       timestamp_us;

  modport source (output valid, output operation, output timestamp_us, input ready);
  modport sink   (input valid, input operation, input timestamp_us, output ready);
endinterface

// ===== design/swsed_out_if.sv =====
// Result channel: one result per accepted request.
interface swsed_out_if;
  logic                  valid;
  logic                  ready;
  logic                  start_accepted;
  logic [15:0]           elapsed_us;
  swsed_pkg::phase_t     phase;
  swsed_pkg::outcome_t   outcome;
  logic [15:0]           humidity;
  logic signed [15:0]    temperature;

  modport source (output valid, output start_accepted, output elapsed_us, output phase,
                  output outcome, output humidity, output temperature, input ready);
  modport sink   (input valid, input start_accepted, input elapsed_us, input phase,
                  input outcome, input humidity, input temperature, output ready);
endinterface

// ===== design/swsed_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface swsed_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [swsed_pkg::CFG_IDX_W-1:0]    index;
  logic [15:0]                        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/swsed_cfg_regs.sv =====
// Timing window registers written through the configuration channel.
module swsed_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  swsed_cfg_if.sink       cfg_if,
  output swsed_pkg::cfg_t cfg
);

  swsed_pkg::cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wake_min_us          <= swsed_pkg::WAKE_MIN_RST;
      cfg_r.wake_max_us          <= swsed_pkg::WAKE_MAX_RST;
      cfg_r.bit_min_us           <= swsed_pkg::BIT_MIN_RST;
      cfg_r.bit_one_threshold_us <= swsed_pkg::BIT_ONE_RST;
      cfg_r.bit_max_us           <= swsed_pkg::BIT_MAX_RST;
    end else if (cfg_if.valid) begin
      // Writes to indexes past the last register are dropped.
      case (cfg_if.index)
        swsed_pkg::CFG_WAKE_MIN: cfg_r.wake_min_us          <= cfg_if.data;
        swsed_pkg::CFG_WAKE_MAX: cfg_r.wake_max_us          <= cfg_if.data;
        swsed_pkg::CFG_BIT_MIN:  cfg_r.bit_min_us           <= cfg_if.data;
        swsed_pkg::CFG_BIT_ONE:  cfg_r.bit_one_threshold_us <= cfg_if.data;
        swsed_pkg::CFG_BIT_MAX:  cfg_r.bit_max_us           <= cfg_if.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/single_wire_sensor_edge_decoder_top.sv =====
// Single-wire sensor edge decoder: a start request arms a read unless one is under way, and
// each falling-edge request measures the interval since the previous edge or start, checks
// the wake-up and bit windows, shifts in 40 bits MSB first, and on the last bit checks the
// byte sum and latches humidity and the sign-magnitude temperature as two's complement.
// Every request yields exactly one result. The block takes one request per cycle while the
// result register is empty or being taken; a request goes through an input register and
// then a result register, which presents its result. The decode state is updated by
// combinational logic between those registers, which is what lets back-to-back requests
// see each other's effect. Input ready drops only while the result register is full and not being taken.
module single_wire_sensor_edge_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  swsed_in_if.sink    in_if,
  swsed_out_if.source out_if,
  swsed_cfg_if.sink   cfg_if
);

  swsed_pkg::cfg_t cfg;

  swsed_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Input register. Only the low 16 bits of a timestamp affect any interval.
  logic           in_vld_r;
  swsed_pkg::op_t in_op_r;
  logic [15:0]    in_ts_r;

  // Decode state.
  swsed_pkg::phase_t   phase_r, phase_nxt;
  swsed_pkg::outcome_t outcome_r, outcome_nxt;
  logic [15:0]         last_edge_r, last_edge_nxt;
  logic [7:0]          frame_r [swsed_pkg::FRAME_LEN];
  logic [7:0]          frame_nxt [swsed_pkg::FRAME_LEN];
  logic [2:0]          bit_pos_r, bit_pos_nxt;
  logic [2:0]          byte_idx_r, byte_idx_nxt;
  logic [15:0]         humidity_r, humidity_nxt;
  logic [15:0]         temperature_r, temperature_nxt;

  // Result register.
  logic                out_vld_r;
  logic                accepted_r, accepted_nxt;
  logic [15:0]         elapsed_r, elapsed_nxt;

  logic                advance;
  logic                fire;
  logic [15:0]         dt;
  logic [7:0]          sum;
  logic [14:0]         mag;

  assign advance     = !out_vld_r || out_if.ready;
  assign in_if.ready = !in_vld_r || advance;
  assign fire        = in_vld_r && advance;
  assign dt          = in_ts_r - last_edge_r;

  always_comb begin
    phase_nxt       = phase_r;
    outcome_nxt     = outcome_r;
    last_edge_nxt   = last_edge_r;
    frame_nxt       = frame_r;
    bit_pos_nxt     = bit_pos_r;
    byte_idx_nxt    = byte_idx_r;
    humidity_nxt    = humidity_r;
    temperature_nxt = temperature_r;
    accepted_nxt    = 1'b0;
    elapsed_nxt     = '0;
    sum             = '0;
    mag             = '0;

    if (in_op_r == swsed_pkg::OP_START) begin
      if (phase_r == swsed_pkg::PH_INVALID || phase_r == swsed_pkg::PH_DONE) begin
        for (int i = 0; i < swsed_pkg::FRAME_LEN; i++) begin
          frame_nxt[i] = '0;
        end
        bit_pos_nxt   = 3'd7;
        byte_idx_nxt  = '0;
        last_edge_nxt = in_ts_r;
        phase_nxt     = swsed_pkg::PH_WAKING;
        accepted_nxt  = 1'b1;
      end
    end else begin
      elapsed_nxt   = dt;
      last_edge_nxt = in_ts_r;
      case (phase_r)
        swsed_pkg::PH_WAKING: begin
          if (dt >= cfg.wake_min_us && dt <= cfg.wake_max_us) begin
            phase_nxt = swsed_pkg::PH_READING;
          end else begin
            outcome_nxt = swsed_pkg::OC_WAKE_ERR;
            phase_nxt   = swsed_pkg::PH_INVALID;
          end
        end
        swsed_pkg::PH_READING: begin
          if (dt < cfg.bit_min_us || dt > cfg.bit_max_us ||
              byte_idx_r >= 3'(swsed_pkg::FRAME_LEN)) begin
            outcome_nxt = swsed_pkg::OC_DATA_ERR;
            phase_nxt   = swsed_pkg::PH_INVALID;
          end else begin
            if (dt > cfg.bit_one_threshold_us) begin
              frame_nxt[byte_idx_r][bit_pos_r] = 1'b1;
            end
            if (bit_pos_r == 3'd0) begin
              bit_pos_nxt  = 3'd7;
              byte_idx_nxt = byte_idx_r + 3'd1;
              if (byte_idx_r == 3'(swsed_pkg::FRAME_LEN - 1)) begin
                // Last bit of the frame: the checksum sees the byte just completed.
                sum = frame_nxt[0] + frame_nxt[1] + frame_nxt[2] + frame_nxt[3];
                if (frame_nxt[4] != sum) begin
                  outcome_nxt = swsed_pkg::OC_SUM_ERR;
                  phase_nxt   = swsed_pkg::PH_INVALID;
                end else begin
                  humidity_nxt = {frame_nxt[0], frame_nxt[1]};
                  mag = {7'(frame_nxt[2] & swsed_pkg::MAG_MASK), frame_nxt[3]};
                  if ((frame_nxt[2] & swsed_pkg::SIGN_MASK) != 8'd0) begin
                    temperature_nxt = 16'd0 - {1'b0, mag};
                  end else begin
                    temperature_nxt = {1'b0, mag};
                  end
                  outcome_nxt = swsed_pkg::OC_OK;
                  phase_nxt   = swsed_pkg::PH_DONE;
                end
              end
            end else begin
              bit_pos_nxt = bit_pos_r - 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_r <= in_if.valid;
    end
    if (in_if.valid && in_if.ready) begin
      in_op_r <= in_if.operation;
      in_ts_r <= in_if.timestamp_us[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= swsed_pkg::PH_INVALID;
      outcome_r     <= swsed_pkg::OC_NONE;
      last_edge_r   <= '0;
      bit_pos_r     <= 3'd7;
      byte_idx_r    <= '0;
      humidity_r    <= '0;
      temperature_r <= '0;
      for (int i = 0; i < swsed_pkg::FRAME_LEN; i++) begin
        frame_r[i] <= '0;
      end
    end else if (fire) begin
      phase_r       <= phase_nxt;
      outcome_r     <= outcome_nxt;
      last_edge_r   <= last_edge_nxt;
      bit_pos_r     <= bit_pos_nxt;
      byte_idx_r    <= byte_idx_nxt;
      humidity_r    <= humidity_nxt;
      temperature_r <= temperature_nxt;
      frame_r       <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
    if (fire) begin
      accepted_r <= accepted_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

  // Phase, outcome and readings in the result are the state left by that request, which
  // stays in place until the next request advances.
  assign out_if.valid          = out_vld_r;
  assign out_if.start_accepted = accepted_r;
  assign out_if.elapsed_us     = elapsed_r;
  assign out_if.phase          = phase_r;
  assign out_if.outcome        = outcome_r;
  assign out_if.humidity       = humidity_r;
  assign out_if.temperature    = temperature_r;

endmodule
